// ----- sv/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and codes for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  typedef enum logic [1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_FREE   = 2'd1,
    FUNC_RESIZE = 2'd2,
    FUNC_ALT    = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_FULL      = 3'd3,
    ST_DOUBLE    = 3'd4,
    ST_UNKNOWN   = 3'd5
  } status_e;

  localparam int unsigned AlignMask = 7;

endpackage

// ----- sv/ffha_ram.sv -----
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with block splitting over a chained block table.
// ----------------------------------------------------------------------------
// Each visited block in the chain passes through S_RD, S_WAIT and S_EVAL:
// allocate walks the chain until the first fitting free block (or the whole
// chain, then appends at the break); free and resize walk until the
// addressed block. Resize that must move walks the chain twice. The walk is
// set by the single read port of the block table RAMs. One request is in
// work at a time; in_stall_o is high until the result is transferred.
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int HeapBytes   = 65536,
  parameter int MaxBlocks   = 64,
  parameter int HeaderBytes = 32,
  parameter int MinPayload  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [16:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] req_size_i,
  input  logic [15:0] block_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] result_address_o,
  output logic [2:0]  status_o,
  output logic [15:0] copy_bytes_o
);

  localparam int IW = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
  localparam int CW = $clog2(MaxBlocks + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MaxBlocks);
  localparam logic [16:0] HeapLim = 17'(HeapBytes);
  localparam logic [17:0] Hdr = 18'(HeaderBytes);
  localparam logic [17:0] SplitAdd = 18'(2 * HeaderBytes + MinPayload);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_RD, S_WAIT, S_EVAL, S_SPLIT, S_APPEND, S_LINK,
    S_DONE, S_OUT
  } state_e;

  typedef enum logic [1:0] {W_LOCATE, W_ALLOC} walk_e;

  state_e         state_q;
  walk_e          walk_q;
  logic [1:0]     func_q;
  logic [15:0]    req_q, ba_q;
  logic [16:0]    limit_q;
  logic [16:0]    brk_q;
  logic [CW-1:0]  cnt_q, k_q;
  logic [IW-1:0]  cur_q, last_q, idx_q;
  logic [MaxBlocks-1:0] free_q;
  logic [15:0]    old_q;
  logic           resize_q;
  logic [15:0]    addr_q, copy_q;
  logic [2:0]     st_q;
  // index of the block being resized, captured apart from the append link
  logic [IW-1:0]  ba_idx_q;

  // table rams
  logic [IW-1:0]  waddr, raddr;
  logic [15:0]    wh, ws, rh, rs;
  logic [IW-1:0]  wn, rn;
  logic           weh, wes, wen;

  ffha_ram #(.Width(16), .Depth(MaxBlocks)) u_hdr (
    .clk_i, .we_i(weh), .waddr_i(waddr), .wdata_i(wh), .raddr_i(raddr), .rdata_o(rh));
  ffha_ram #(.Width(16), .Depth(MaxBlocks)) u_size (
    .clk_i, .we_i(wes), .waddr_i(waddr), .wdata_i(ws), .raddr_i(raddr), .rdata_o(rs));
  ffha_ram #(.Width(IW), .Depth(MaxBlocks)) u_next (
    .clk_i, .we_i(wen), .waddr_i(waddr), .wdata_i(wn), .raddr_i(raddr), .rdata_o(rn));

  assign raddr = cur_q;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign result_address_o = addr_q;
  assign status_o = st_q;
  assign copy_bytes_o = copy_q;

  logic [17:0] pay, need, blk, brk_sum;
  logic [IW-1:0] nidx;
  assign pay  = {2'b0, rh} + Hdr;
  assign need = {2'b0, req_q} + SplitAdd;
  assign blk  = ({2'b0, req_q} + Hdr + 18'(AlignMask)) & ~18'(AlignMask);
  assign brk_sum = {1'b0, brk_q} + blk;
  assign nidx = cnt_q[IW-1:0];

  logic [16:0] lim_eff;
  assign lim_eff = (limit_q > HeapLim) ? HeapLim : limit_q;

  // write port mux
  always_comb begin
    weh = 1'b0; wes = 1'b0; wen = 1'b0;
    waddr = cur_q; wh = 16'(pay + {2'b0, req_q}); ws = 16'd0; wn = rn;
    unique case (state_q)
      S_SPLIT: begin
        weh = 1'b1; wes = 1'b1; wen = 1'b1; waddr = nidx;
        wh = 16'(pay + {2'b0, req_q});
        ws = rs - req_q - 16'(HeaderBytes);
        wn = rn;
      end
      S_LINK: begin
        wes = 1'b1; wen = 1'b1; waddr = cur_q; ws = req_q; wn = nidx;
      end
      S_APPEND: begin
        weh = 1'b1; wes = 1'b1; wen = 1'b1; waddr = nidx;
        wh = brk_q[15:0]; ws = req_q; wn = '0;
      end
      S_DONE: begin
        wen = resize_q; waddr = last_q; wn = idx_q;
      end
      default: ;
    endcase
  end

  logic [IW-1:0] succ;
  assign succ = (32'(rn) < MaxBlocks) ? rn : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      walk_q <= W_LOCATE;
      limit_q <= 17'h10000;
      brk_q <= '0;
      cnt_q <= '0;
      free_q <= '0;
      k_q <= '0;
      cur_q <= '0;
      last_q <= '0;
      idx_q <= '0;
      resize_q <= 1'b0;
      func_q <= '0; req_q <= '0; ba_q <= '0; old_q <= '0;
      addr_q <= '0; copy_q <= '0; st_q <= ST_OK;
    end else begin
      resize_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (cfg_valid_i) limit_q <= cfg_data_i;
          if (in_valid_i) begin
            func_q <= func_i; req_q <= req_size_i; ba_q <= block_address_i;
            state_q <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          addr_q <= '0; copy_q <= '0; st_q <= ST_OK;
          k_q <= '0; cur_q <= '0; last_q <= '0;
          if ((func_q == FUNC_FREE || func_q == FUNC_RESIZE) && ba_q != 16'd0) begin
            walk_q <= W_LOCATE; state_q <= S_RD;
          end else if (func_q == FUNC_FREE) begin
            state_q <= S_OUT;
          end else if (req_q == 16'd0) begin
            st_q <= ST_ZERO; state_q <= S_OUT;
          end else begin
            old_q <= '0; walk_q <= W_ALLOC; state_q <= S_RD;
          end
        end
        S_RD: begin
          if (k_q >= cnt_q) begin
            if (walk_q == W_LOCATE) begin
              st_q <= ST_UNKNOWN; state_q <= S_OUT;
            end else if (cnt_q >= MaxCnt) begin
              st_q <= ST_FULL; state_q <= S_OUT;
            end else if (brk_sum > {1'b0, lim_eff}) begin
              st_q <= ST_EXHAUSTED; state_q <= S_OUT;
            end else begin
              state_q <= S_APPEND;
            end
          end else state_q <= S_WAIT;
        end
        S_WAIT: state_q <= S_EVAL;
        S_EVAL: begin
          if (walk_q == W_LOCATE) begin
            if (pay == {2'b0, ba_q}) begin
              if (free_q[cur_q]) begin
                st_q <= ST_DOUBLE; state_q <= S_OUT;
              end else if (func_q == FUNC_FREE) begin
                free_q[cur_q] <= 1'b1; state_q <= S_OUT;
              end else if (rs >= req_q) begin
                addr_q <= ba_q; state_q <= S_OUT;
              end else begin
                idx_q <= cur_q; old_q <= rs;
                walk_q <= W_ALLOC; k_q <= '0; cur_q <= '0; last_q <= '0;
                state_q <= S_RD;
              end
            end else begin
              k_q <= k_q + 1'b1; cur_q <= succ; state_q <= S_RD;
            end
          end else if (free_q[cur_q] && rs >= req_q) begin
            free_q[cur_q] <= 1'b0;
            addr_q <= pay[15:0];
            if ({2'b0, rs} >= need && cnt_q < MaxCnt) state_q <= S_SPLIT;
            else state_q <= S_DONE;
          end else begin
            last_q <= cur_q; k_q <= k_q + 1'b1; cur_q <= succ; state_q <= S_RD;
          end
        end
        S_SPLIT: begin
          free_q[nidx] <= 1'b1; state_q <= S_LINK;
        end
        S_LINK: begin
          cnt_q <= cnt_q + 1'b1; state_q <= S_DONE;
        end
        S_APPEND: begin
          free_q[nidx] <= 1'b0;
          addr_q <= 16'({1'b0, brk_q} + Hdr);
          brk_q <= brk_sum[16:0];
          cnt_q <= cnt_q + 1'b1;
          idx_q <= nidx;
          resize_q <= (cnt_q != '0);
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (func_q == FUNC_RESIZE && ba_q != 16'd0) begin
            copy_q <= old_q;
            free_q[ba_idx_q] <= 1'b1;
          end
          state_q <= S_OUT;
        end
        S_OUT: if (!out_stall_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ba_idx_q <= '0;
    else if (state_q == S_EVAL && walk_q == W_LOCATE) ba_idx_q <= cur_q;
  end

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit heap allocator: directed requests,
// then random allocate/free/resize/alt traffic under several heap limits,
// with a request-level model of block table and break predicting each result.
// ----------------------------------------------------------------------------
module tb;
  import ffha_pkg::*;

  typedef struct packed {
    func_e       fn;
    logic [15:0] req;
    logic [15:0] addr;
  } request_t;

  typedef struct packed {
    logic [15:0] addr;
    status_e     st;
    logic [15:0] copy;
  } grant_t;

  localparam int Blocks = 64;
  localparam int Hdr    = 32;
  localparam int MinPay = 8;
  localparam int Drain  = 2 * 3 * Blocks + 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [16:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  func_i = '0;
  logic [15:0] req_size_i = '0;
  logic [15:0] block_address_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] result_address_o;
  logic [2:0]  status_o;
  logic [15:0] copy_bytes_o;

  first_fit_heap_allocator uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow allocator state
  logic [15:0] blk_hdr [Blocks];
  logic [15:0] blk_len [Blocks];
  logic        blk_free [Blocks];
  logic [5:0]  blk_next [Blocks];
  int unsigned blk_count;
  int unsigned heap_brk;
  int unsigned heap_lim;

  request_t pending_reqs[$];
  grant_t   expected_grants[$];
  int       send_idle_pct, stall_pct;
  int       errors;
  bit       in_taken;

  function automatic int find_block(int unsigned addr);
    int unsigned cur;
    cur = 0;
    for (int unsigned k = 0; k < blk_count; k++) begin
      if (32'(blk_hdr[cur]) + Hdr == addr) return cur;
      cur = blk_next[cur];
    end
    return -1;
  endfunction

  function automatic status_e grant_block(int unsigned req, output logic [15:0] addr);
    int unsigned cur, last, tot, pay, lim, sz, n;
    cur = 0;
    last = 0;
    addr = '0;
    if (req == 0) return ST_ZERO;
    for (int unsigned k = 0; k < blk_count; k++) begin
      if (blk_free[cur] && blk_len[cur] >= req) begin
        tot = blk_len[cur];
        pay = 32'(blk_hdr[cur]) + Hdr;
        blk_free[cur] = 1'b0;
        if (tot >= req + 2 * Hdr + MinPay && blk_count < Blocks) begin
          n = blk_count;
          blk_hdr[n] = 16'(pay + req);
          blk_len[n] = 16'(tot - req - Hdr);
          blk_free[n] = 1'b1;
          blk_next[n] = blk_next[cur];
          blk_next[cur] = 6'(n);
          blk_len[cur] = 16'(req);
          blk_count = n + 1;
        end
        addr = 16'(pay);
        return ST_OK;
      end
      last = cur;
      cur = blk_next[cur];
    end
    if (blk_count >= Blocks) return ST_FULL;
    lim = (heap_lim > 65536) ? 65536 : heap_lim;
    sz = (req + Hdr + AlignMask) & ~AlignMask;
    if (heap_brk + sz > lim) return ST_EXHAUSTED;
    n = blk_count;
    blk_hdr[n] = 16'(heap_brk);
    blk_len[n] = 16'(req);
    blk_free[n] = 1'b0;
    blk_next[n] = '0;
    if (n > 0) blk_next[last] = 6'(n);
    addr = 16'(heap_brk + Hdr);
    heap_brk += sz;
    blk_count = n + 1;
    return ST_OK;
  endfunction

  function automatic grant_t serve_request(request_t r);
    grant_t g;
    int     idx;
    logic [15:0] a;
    g = '{addr: '0, st: ST_OK, copy: '0};
    if (r.fn == FUNC_FREE) begin
      if (r.addr != 0) begin
        idx = find_block(r.addr);
        if (idx < 0) g.st = ST_UNKNOWN;
        else if (blk_free[idx]) g.st = ST_DOUBLE;
        else blk_free[idx] = 1'b1;
      end
    end else if (r.fn == FUNC_RESIZE && r.addr != 0) begin
      idx = find_block(r.addr);
      if (idx < 0) g.st = ST_UNKNOWN;
      else if (blk_free[idx]) g.st = ST_DOUBLE;
      else if (blk_len[idx] >= r.req) g.addr = r.addr;
      else begin
        g.st = grant_block(r.req, a);
        g.addr = a;
        if (g.st == ST_OK) begin
          g.copy = blk_len[idx];
          blk_free[idx] = 1'b1;
        end
      end
    end else begin
      g.st = grant_block(r.req, a);
      g.addr = a;
    end
    return g;
  endfunction

  function automatic void queue_request(func_e fn, int unsigned req, int unsigned addr);
    request_t r;
    r = '{fn: fn, req: 16'(req), addr: 16'(addr)};
    pending_reqs.push_back(r);
    expected_grants.push_back(serve_request(r));
  endfunction

  function automatic int unsigned live_payload();
    if (blk_count == 0) return 0;
    return 32'(blk_hdr[$urandom_range(0, blk_count - 1)]) + Hdr;
  endfunction

  function automatic int unsigned rand_size();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return $urandom_range(0, 65535);
      2:       return 65535;
      3, 4:    return $urandom_range(200, 3000);
      default: return $urandom_range(1, 200);
    endcase
  endfunction

  function automatic void queue_random();
    int unsigned sel, a;
    sel = $urandom_range(0, 99);
    a = ($urandom_range(0, 9) < 7) ? live_payload() : $urandom_range(0, 65535);
    if ($urandom_range(0, 19) == 0) a = 0;
    if (sel < 45) queue_request(FUNC_ALLOC, rand_size(), $urandom_range(0, 65535));
    else if (sel < 75) queue_request(FUNC_FREE, $urandom_range(0, 65535), a);
    else if (sel < 95) queue_request(FUNC_RESIZE, rand_size(), a);
    else queue_request(FUNC_ALT, rand_size(), $urandom_range(0, 65535));
  endfunction

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || expected_grants.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic write_limit(int unsigned v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= 17'(v);
    do @(posedge clk_i); while (!cfg_ready_o);
    heap_lim = v & 32'h1FFFF;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    in_taken = in_valid_i && !in_stall_o;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          request_t r;
          r = pending_reqs.pop_front();
          in_valid_i      <= 1'b1;
          func_i          <= r.fn;
          req_size_i      <= r.req;
          block_address_i <= r.addr;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (expected_grants.size() == 0) begin
        errors++;
        $display("%0t: unexpected result addr=%h status=%0d copy=%0d", $time,
                 result_address_o, status_o, copy_bytes_o);
      end else begin
        grant_t g;
        g = expected_grants.pop_front();
        if (result_address_o !== g.addr) begin
          errors++;
          $display("%0t: result_address exp %h got %h", $time, g.addr, result_address_o);
        end
        if (status_o !== g.st) begin
          errors++;
          $display("%0t: status exp %0d got %0d", $time, g.st, status_o);
        end
        if (copy_bytes_o !== g.copy) begin
          errors++;
          $display("%0t: copy_bytes exp %0d got %0d", $time, g.copy, copy_bytes_o);
        end
      end
    end
  end

  initial begin
    int unsigned limits [6];
    int unsigned a, b;
    limits = '{2000, 131071, 0, 600, 40000, 65536};
    errors = 0;
    blk_count = 0;
    heap_brk = 0;
    heap_lim = 65536;
    for (int i = 0; i < Blocks; i++) blk_free[i] = 1'b0;
    send_idle_pct = 12;
    stall_pct = 58;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_limit(65536);
    queue_request(FUNC_ALLOC, 0, 0);
    queue_request(FUNC_ALLOC, 1, 0);
    a = 32'(expected_grants[$].addr);
    queue_request(FUNC_ALLOC, 100, 0);
    b = 32'(expected_grants[$].addr);
    queue_request(FUNC_FREE, 0, b);
    queue_request(FUNC_FREE, 0, b);
    queue_request(FUNC_FREE, 0, 0);
    queue_request(FUNC_FREE, 0, 16'hFFFF);
    queue_request(FUNC_RESIZE, 5, b);
    queue_request(FUNC_RESIZE, 40, 0);
    queue_request(FUNC_ALLOC, 8, 0);
    queue_request(FUNC_RESIZE, 1, a);
    queue_request(FUNC_RESIZE, 0, a);
    queue_request(FUNC_RESIZE, 300, a);
    queue_request(FUNC_RESIZE, 10, 3);
    queue_request(FUNC_ALLOC, 65535, 0);
    queue_request(FUNC_RESIZE, 65535, b + 8);
    queue_request(FUNC_ALT, 16, 16'hFFFF);
    queue_request(FUNC_ALLOC, 16'h5555, 16'hAAAA);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 12 : (p < 4) ? 58 : 0;
      stall_pct     = (p < 2) ? 58 : (p < 4) ? 12 : 0;
      write_limit(limits[p]);
      for (int i = 0; i < 115; i++) queue_random();
      wait_idle();
    end

    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #60000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- files.f -----
sv/ffha_pkg.sv
sv/ffha_ram.sv
sv/first_fit_heap_allocator.sv
dv/tb.sv
